// File: rtl/tpst_pkg.sv
// Shared constants, codes and types of the timed phase sequencer table.
package tpst_pkg;

  localparam int unsigned MAX_SEQUENCES = 4;
  localparam int unsigned MAX_PHASES    = 8;

  localparam int unsigned SL_W   = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int unsigned PH_W   = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PHASES + 1);
  localparam int unsigned DEPTH  = MAX_SEQUENCES * MAX_PHASES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TIMER_W  = 33;

  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [TIME_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EV_SCENE_BEGIN = 3'd0,
    EV_PHASE_BEGIN = 3'd1,
    EV_PHASE_END   = 3'd2,
    EV_SCENE_END   = 3'd3,
    EV_ERROR       = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_TOO_MANY  = 2'd2
  } err_e;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_COPY   = 13'b0000000000010,
    ST_SRD    = 13'b0000000000100,
    ST_EMIT1  = 13'b0000000001000,
    ST_EMIT2  = 13'b0000000010000,
    ST_TSCAN  = 13'b0000000100000,
    ST_TCHK   = 13'b0000001000000,
    ST_TRD_E  = 13'b0000010000000,
    ST_TEM_E  = 13'b0000100000000,
    ST_TRD_B  = 13'b0001000000000,
    ST_TEM_B  = 13'b0010000000000,
    ST_TEM_SE = 13'b0100000000000,
    ST_FLUSH  = 13'b1000000000000
  } state_e;

  typedef struct packed {
    event_e              ev;
    logic [HANDLE_W-1:0] id;
    logic [CODE_W-1:0]   phase;
    err_e                err;
  } result_t;

endpackage

// File: rtl/timed_phase_sequencer_table_top.sv
// Top level of the timed phase sequencer table: entry table, phase memory and sequencer.
// Steps per item: a start element is staged; a commit copies the staged codes, emits scene
// begin and phase begin, then flushes; an error or empty start emits, then flushes; a stop reads.
// A stop then emits phase end and scene end. Tick: a scan over all entries picks the active entry
// with the lowest handle; each check that fires emits phase end, then phase begin or scene end.
// Reset (rst_ni low, asynchronous) clears valid bits and control, not the phase memory.
module timed_phase_sequencer_table_top
  import tpst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // scene_handle[63:0], phase_code[95:64], period[127:96], elapsed[159:128]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[1:0], empty_list[2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // scene_id[63:0], phase_value[95:64], error_code[97:96], zero fill[103:98]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // event_res[2:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  // input fields
  logic [HANDLE_W-1:0] in_handle;
  logic [CODE_W-1:0]   in_code;
  logic [TIME_W-1:0]   in_period;
  logic [TIME_W-1:0]   in_elapsed;
  kind_e               in_kind;
  logic                in_empty;

  assign in_handle  = s_axis_tdata_i[63:0];
  assign in_code    = s_axis_tdata_i[95:64];
  assign in_period  = s_axis_tdata_i[127:96];
  assign in_elapsed = s_axis_tdata_i[159:128];
  assign in_kind    = kind_e'(s_axis_tuser_i[1:0]);
  assign in_empty   = s_axis_tuser_i[2];

  // entry table
  logic [MAX_SEQUENCES-1:0] valid_q;
  logic [HANDLE_W-1:0]      handle_q [MAX_SEQUENCES];
  logic [TIME_W-1:0]        period_q [MAX_SEQUENCES];
  logic [TIMER_W-1:0]       timer_q  [MAX_SEQUENCES];
  logic [CNT_W-1:0]         cur_q    [MAX_SEQUENCES];
  logic [CNT_W-1:0]         count_q  [MAX_SEQUENCES];

  // staging list
  logic [CODE_W-1:0] stage_q [MAX_PHASES];
  logic [CNT_W-1:0]  fill_q;
  logic              ovf_q;

  // phase memory
  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rdata_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;

  // sequencer
  state_e            state_q;
  logic [SL_W-1:0]   slot_q;
  logic [PH_W-1:0]   ci_q;
  logic [CNT_W-1:0]  copy_n_q;
  logic [HANDLE_W-1:0] id_q;
  logic [CODE_W-1:0] ph_q;
  event_e            e1_q, e2_q;
  err_e              err_q;
  logic              has_e2_q;
  logic [TIME_W-1:0] dt_q;
  logic [MAX_SEQUENCES-1:0] done_q;
  logic [SL_W-1:0]   sc_q, best_q;
  logic              best_v_q;

  // result holding and output
  result_t pend_q, out_q;
  logic    pend_v_q, m_valid_q, m_last_q;

  logic    s_fire, out_free, can_emit;
  logic    emit_req;
  result_t emit_res;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign can_emit        = !pend_v_q || out_free;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_q.ev;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {6'd0, out_q.err, out_q.phase, out_q.id};

  // lookup by handle and first free slot
  logic            hit, free_v;
  logic [SL_W-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_v = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MAX_SEQUENCES; i++) begin
      if (valid_q[i] && handle_q[i] == in_handle && !hit) begin
        hit = 1'b1;
        hit_idx = SL_W'(i);
      end
      if (!valid_q[i] && !free_v) begin
        free_v = 1'b1;
        free_idx = SL_W'(i);
      end
    end
  end

  // scan step: one candidate entry per cycle
  logic            cand, take;
  logic [SL_W-1:0] sel;
  logic            sel_v;
  always_comb begin
    cand  = valid_q[sc_q] && !done_q[sc_q];
    take  = cand && (!best_v_q || handle_q[sc_q] < handle_q[best_q]);
    sel   = take ? sc_q : best_q;
    sel_v = take || best_v_q;
  end

  logic [TIMER_W-1:0] per_ext;
  logic               fire_ok;
  logic [CNT_W-1:0]   cur_next;
  assign per_ext  = {1'b0, period_q[slot_q]};
  assign fire_ok  = (cur_q[slot_q] < count_q[slot_q]) && (timer_q[slot_q] >= per_ext);
  assign cur_next = cur_q[slot_q] + CNT_W'(1);

  assign rd_addr = ADDR_W'(slot_q) * ADDR_W'(MAX_PHASES) + ADDR_W'(cur_q[slot_q]);
  assign wr_addr = ADDR_W'(slot_q) * ADDR_W'(MAX_PHASES) + ADDR_W'(ci_q);
  assign wr_en   = (state_q == ST_COPY);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= stage_q[ci_q];
    end
    rdata_q <= mem[rd_addr];
  end

  // result to emit this cycle
  always_comb begin
    emit_req = 1'b0;
    emit_res.ev    = e1_q;
    emit_res.id    = id_q;
    emit_res.phase = '0;
    emit_res.err   = ERR_NONE;
    unique case (state_q)
      ST_EMIT1: begin
        emit_req = 1'b1;
        emit_res.ev = e1_q;
        emit_res.phase = (e1_q == EV_PHASE_END) ? rdata_q : '0;
        emit_res.err = err_q;
      end
      ST_EMIT2: begin
        emit_req = 1'b1;
        emit_res.ev = e2_q;
        emit_res.phase = (e2_q == EV_PHASE_BEGIN) ? ph_q : '0;
      end
      ST_TEM_E: begin
        emit_req = 1'b1;
        emit_res.ev = EV_PHASE_END;
        emit_res.phase = rdata_q;
      end
      ST_TEM_B: begin
        emit_req = 1'b1;
        emit_res.ev = EV_PHASE_BEGIN;
        emit_res.phase = rdata_q;
      end
      ST_TEM_SE: begin
        emit_req = 1'b1;
        emit_res.ev = EV_SCENE_END;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  // result holding register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (emit_req && can_emit) begin
        m_valid_q <= pend_v_q || (m_valid_q && !m_axis_tready_i);
        pend_v_q  <= 1'b1;
      end else if (state_q == ST_FLUSH && pend_v_q && out_free) begin
        m_valid_q <= 1'b1;
        pend_v_q  <= 1'b0;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_req && can_emit) begin
      if (pend_v_q) begin
        out_q    <= pend_q;
        m_last_q <= 1'b0;
      end
      pend_q <= emit_res;
    end else if (state_q == ST_FLUSH && pend_v_q && out_free) begin
      out_q    <= pend_q;
      m_last_q <= 1'b1;
    end
  end

  // sequencer control and entry table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      done_q   <= '0;
      sc_q     <= '0;
      best_v_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            id_q <= in_handle;
            unique case (in_kind)
              KIND_START: begin
                if (in_empty) begin
                  fill_q   <= '0;
                  ovf_q    <= 1'b0;
                  if (hit) valid_q[hit_idx] <= 1'b0;
                  e1_q     <= EV_SCENE_BEGIN;
                  e2_q     <= EV_SCENE_END;
                  err_q    <= ERR_NONE;
                  has_e2_q <= 1'b1;
                  state_q  <= ST_EMIT1;
                end else if (!s_axis_tlast_i) begin
                  if (fill_q < CNT_W'(MAX_PHASES)) begin
                    stage_q[fill_q[PH_W-1:0]] <= in_code;
                    fill_q <= fill_q + CNT_W'(1);
                  end else begin
                    ovf_q <= 1'b1;
                  end
                end else if (ovf_q || fill_q == CNT_W'(MAX_PHASES)) begin
                  fill_q   <= '0;
                  ovf_q    <= 1'b0;
                  e1_q     <= EV_ERROR;
                  err_q    <= ERR_TOO_MANY;
                  has_e2_q <= 1'b0;
                  state_q  <= ST_EMIT1;
                end else if (!hit && !free_v) begin
                  fill_q   <= '0;
                  e1_q     <= EV_ERROR;
                  err_q    <= ERR_FULL;
                  has_e2_q <= 1'b0;
                  state_q  <= ST_EMIT1;
                end else begin
                  stage_q[fill_q[PH_W-1:0]] <= in_code;
                  slot_q <= hit ? hit_idx : free_idx;
                  valid_q[hit ? hit_idx : free_idx]  <= 1'b1;
                  handle_q[hit ? hit_idx : free_idx] <= in_handle;
                  period_q[hit ? hit_idx : free_idx] <=
                    (in_period != '0) ? in_period : ONE_Q16;
                  timer_q[hit ? hit_idx : free_idx]  <= '0;
                  cur_q[hit ? hit_idx : free_idx]    <= '0;
                  count_q[hit ? hit_idx : free_idx]  <= fill_q + CNT_W'(1);
                  copy_n_q <= fill_q + CNT_W'(1);
                  ph_q     <= (fill_q == '0) ? in_code : stage_q[0];
                  fill_q   <= '0;
                  ci_q     <= '0;
                  e1_q     <= EV_SCENE_BEGIN;
                  e2_q     <= EV_PHASE_BEGIN;
                  err_q    <= ERR_NONE;
                  has_e2_q <= 1'b1;
                  state_q  <= ST_COPY;
                end
              end
              KIND_STOP: begin
                if (hit) begin
                  valid_q[hit_idx] <= 1'b0;
                  slot_q   <= hit_idx;
                  e1_q     <= EV_PHASE_END;
                  e2_q     <= EV_SCENE_END;
                  err_q    <= ERR_NONE;
                  has_e2_q <= 1'b1;
                  state_q  <= ST_SRD;
                end
              end
              KIND_TICK: begin
                dt_q     <= in_elapsed;
                done_q   <= '0;
                sc_q     <= '0;
                best_v_q <= 1'b0;
                state_q  <= ST_TSCAN;
              end
              KIND_NONE: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_COPY: begin
          // one staged code per cycle into the slot's region
          if (CNT_W'(ci_q) + CNT_W'(1) == copy_n_q) begin
            state_q <= ST_EMIT1;
          end else begin
            ci_q <= ci_q + PH_W'(1);
          end
        end
        ST_SRD: begin
          state_q <= ST_EMIT1;
        end
        ST_EMIT1: begin
          if (can_emit) state_q <= has_e2_q ? ST_EMIT2 : ST_FLUSH;
        end
        ST_EMIT2: begin
          if (can_emit) state_q <= ST_FLUSH;
        end
        ST_TSCAN: begin
          best_q <= sel;
          if (sc_q == SL_W'(MAX_SEQUENCES - 1)) begin
            sc_q     <= '0;
            best_v_q <= 1'b0;
            if (sel_v) begin
              slot_q       <= sel;
              id_q         <= handle_q[sel];
              done_q[sel]  <= 1'b1;
              timer_q[sel] <= timer_q[sel] + {1'b0, dt_q};
              state_q      <= ST_TCHK;
            end else begin
              state_q <= ST_FLUSH;
            end
          end else begin
            best_v_q <= sel_v;
            sc_q     <= sc_q + SL_W'(1);
          end
        end
        ST_TCHK: begin
          if (fire_ok) begin
            timer_q[slot_q] <= timer_q[slot_q] - per_ext;
            state_q <= ST_TRD_E;
          end else begin
            state_q <= ST_TSCAN;
          end
        end
        ST_TRD_E: begin
          state_q <= ST_TEM_E;
        end
        ST_TEM_E: begin
          if (can_emit) begin
            cur_q[slot_q] <= cur_next;
            if (cur_next < count_q[slot_q]) begin
              state_q <= ST_TRD_B;
            end else begin
              valid_q[slot_q] <= 1'b0;
              state_q <= ST_TEM_SE;
            end
          end
        end
        ST_TRD_B: begin
          state_q <= ST_TEM_B;
        end
        ST_TEM_B: begin
          if (can_emit) state_q <= ST_TCHK;
        end
        ST_TEM_SE: begin
          if (can_emit) state_q <= ST_TSCAN;
        end
        ST_FLUSH: begin
          if (!pend_v_q || out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/tpst_checker.sv
// Port-level checks of the timed phase sequencer table, bound to the top level.
module tpst_checker
  import tpst_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input logic                  m_axis_tlast_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == EV_ERROR |-> m_axis_tlast_o)
    else $error("error result is not the last of its run");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == EV_ERROR |->
      m_axis_tdata_o[95:64] == '0 && m_axis_tdata_o[97:96] != ERR_NONE)
    else $error("malformed error result");

  a_no_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != EV_ERROR |-> m_axis_tdata_o[97:96] == ERR_NONE)
    else $error("error code on a non-error result");

  a_begin_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == EV_SCENE_BEGIN |-> !m_axis_tlast_o)
    else $error("scene begin closed a run");

endmodule

bind timed_phase_sequencer_table_top tpst_checker u_tpst_checker (.*);
